### sv/crdm_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and font for the countdown matrix renderer
// no dependencies; used by crdm_front, crdm_queue, crdm_back and the top level

package crdm_pkg;

   // frame geometry
   localparam int ROWS_PER_FRAME = 16;
   localparam int ROW_WIDTH      = 4;
   localparam int PIX_WIDTH      = 16;
   localparam int SECONDS_WIDTH  = 16;
   localparam int COUNT_WIDTH    = SECONDS_WIDTH - 1;
   localparam logic [ROW_WIDTH-1:0] ROW_LAST = ROW_WIDTH'(ROWS_PER_FRAME - 1);

   // glyph placement and fixed patterns
   localparam int GLYPH_SHIFT = 4;
   localparam int GLYPH_WIDTH = 7;
   localparam logic [PIX_WIDTH-1:0] COLON_PATTERN = 16'h0140;

   // time split constants
   localparam int SECS_PER_MIN = 60;
   localparam int DIGIT_BASE   = 10;
   localparam logic [3:0] MINUTE_LIMIT = 4'd10;

   // reciprocal of 60 scaled by 2^21, exact for every 15-bit count
   localparam int RECIP_SHIFT = 21;
   localparam int RECIP_WIDTH = 16;
   localparam logic [RECIP_WIDTH-1:0] RECIP_60 =
      RECIP_WIDTH'(((1 << RECIP_SHIFT) + SECS_PER_MIN - 1) / SECS_PER_MIN);
   localparam int PROD_WIDTH = COUNT_WIDTH + RECIP_WIDTH;
   localparam int QUOT_WIDTH = PROD_WIDTH - RECIP_SHIFT;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // one decoded item: the three glyph indexes
   typedef struct packed {
      logic [3:0] mins;
      logic [2:0] tens;
      logic [3:0] units;
   } digits_type;

   // 11-entry font, 4 columns of 7 bits; last entry is the exclamation mark
   localparam logic [GLYPH_WIDTH-1:0] GLYPH_FONT [11][4] = '{
      '{7'h3E, 7'h41, 7'h41, 7'h3E},
      '{7'h00, 7'h42, 7'h7F, 7'h40},
      '{7'h66, 7'h51, 7'h49, 7'h46},
      '{7'h22, 7'h49, 7'h49, 7'h36},
      '{7'h1C, 7'h12, 7'h7F, 7'h10},
      '{7'h27, 7'h45, 7'h45, 7'h39},
      '{7'h3C, 7'h4A, 7'h49, 7'h30},
      '{7'h01, 7'h71, 7'h09, 7'h07},
      '{7'h36, 7'h49, 7'h49, 7'h36},
      '{7'h06, 7'h49, 7'h29, 7'h1E},
      '{7'h00, 7'h5F, 7'h5F, 7'h00}
   };

   // one glyph column placed at bits 4..10
   function automatic logic [PIX_WIDTH-1:0] glyph_col(input logic [3:0] glyph,
                                                     input logic [1:0] col);
      logic [3:0] idx;
      idx = (glyph > MINUTE_LIMIT) ? MINUTE_LIMIT : glyph;
      return PIX_WIDTH'(GLYPH_FONT[idx][col]) << GLYPH_SHIFT;
   endfunction

   // pixel pattern of one row, before inversion
   function automatic logic [PIX_WIDTH-1:0] row_pixels(input digits_type dig,
                                                      input logic [ROW_WIDTH-1:0] row);
      logic [ROW_WIDTH-1:0] tens_col;
      logic [PIX_WIDTH-1:0] pix;
      tens_col = row - ROW_WIDTH'(7);
      unique case (row) inside
         [4'd0:4'd3]:   pix = glyph_col(dig.mins, row[1:0]);
         4'd5:          pix = COLON_PATTERN;
         [4'd7:4'd10]:  pix = glyph_col({1'b0, dig.tens}, tens_col[1:0]);
         [4'd12:4'd15]: pix = glyph_col(dig.units, row[1:0]);
         default:       pix = '0;
      endcase
      return pix;
   endfunction

endpackage

### sv/crdm_front.sv
`timescale 1ns / 1ps
// front end: takes seconds, splits them into minute, tens and unit glyph indexes
// two register stages; depends on crdm_pkg

module crdm_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  logic [crdm_pkg::SECONDS_WIDTH-1:0]  in_seconds,
   output logic                                out_valid,
   input  logic                                out_ready,
   output crdm_pkg::digits_type                out_data
);

   logic                                s1_valid_ff;
   logic                                s2_valid_ff;
   logic                                s1_ready;
   logic                                s2_ready;
   logic                                accept;
   logic [crdm_pkg::COUNT_WIDTH-1:0]    count_in;
   logic [crdm_pkg::COUNT_WIDTH-1:0]    count_ff;
   logic [crdm_pkg::PROD_WIDTH-1:0]     prod_in;
   logic [crdm_pkg::PROD_WIDTH-1:0]     prod_ff;
   logic [crdm_pkg::QUOT_WIDTH-1:0]     quot;
   logic [crdm_pkg::SECONDS_WIDTH-1:0]  quot60;
   logic [crdm_pkg::SECONDS_WIDTH-1:0]  rem_wide;
   logic                                rem_over;
   logic [crdm_pkg::QUOT_WIDTH-1:0]     quot_fix;
   logic [5:0]                          rem_in;
   logic [5:0]                          rem_ff;
   logic [3:0]                          mins_in;
   logic [3:0]                          mins_ff;
   logic [2:0]                          tens;
   logic [5:0]                          tens10;

   // elastic two-stage handshake
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_stall = !s1_ready;
   assign accept   = in_valid && s1_ready;

   // negative counts show as zero; reciprocal multiply for the minute split
   assign count_in = in_seconds[crdm_pkg::SECONDS_WIDTH-1] ? '0
                     : in_seconds[crdm_pkg::COUNT_WIDTH-1:0];
   assign prod_in  = crdm_pkg::PROD_WIDTH'(count_in) *
                     crdm_pkg::PROD_WIDTH'(crdm_pkg::RECIP_60);

   // remainder by shift and subtract, one correction step
   assign quot     = prod_ff[crdm_pkg::PROD_WIDTH-1:crdm_pkg::RECIP_SHIFT];
   assign quot60   = (crdm_pkg::SECONDS_WIDTH'(quot) << 6)
                   - (crdm_pkg::SECONDS_WIDTH'(quot) << 2);
   assign rem_wide = crdm_pkg::SECONDS_WIDTH'(count_ff) - quot60;
   assign rem_over = rem_wide >= crdm_pkg::SECONDS_WIDTH'(crdm_pkg::SECS_PER_MIN);
   assign quot_fix = rem_over ? quot + crdm_pkg::QUOT_WIDTH'(1) : quot;
   assign rem_in   = rem_over
                     ? 6'(rem_wide - crdm_pkg::SECONDS_WIDTH'(crdm_pkg::SECS_PER_MIN))
                     : rem_wide[5:0];
   assign mins_in  = (quot_fix > crdm_pkg::QUOT_WIDTH'(crdm_pkg::MINUTE_LIMIT))
                     ? crdm_pkg::MINUTE_LIMIT : quot_fix[3:0];

   // tens and units of the remainder (below 60)
   always_comb begin
      if (rem_ff >= 6'd50)      tens = 3'd5;
      else if (rem_ff >= 6'd40) tens = 3'd4;
      else if (rem_ff >= 6'd30) tens = 3'd3;
      else if (rem_ff >= 6'd20) tens = 3'd2;
      else if (rem_ff >= 6'd10) tens = 3'd1;
      else                      tens = 3'd0;
   end
   assign tens10 = (6'(tens) << 3) + (6'(tens) << 1);

   assign out_valid      = s2_valid_ff;
   assign out_data.mins  = mins_ff;
   assign out_data.tens  = tens;
   assign out_data.units = 4'(rem_ff - tens10);

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
      if (accept) begin
         count_ff <= count_in;
         prod_ff  <= prod_in;
      end
      if (s2_ready && s1_valid_ff) begin
         mins_ff <= mins_in;
         rem_ff  <= rem_in;
      end
   end

endmodule

### sv/crdm_queue.sv
`timescale 1ns / 1ps
// short transaction queue between the front and back ends
// holds decoded digit sets; depends on crdm_pkg

module crdm_queue #(
   parameter int DEPTH = crdm_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  crdm_pkg::digits_type  push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output crdm_pkg::digits_type  head_data
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);

   crdm_pkg::digits_type    store_ff [DEPTH];
   logic [PTR_WIDTH-1:0]    wr_ptr_ff;
   logic [PTR_WIDTH-1:0]    rd_ptr_ff;
   logic [CNT_WIDTH-1:0]    count_ff;
   logic                    do_push;
   logic                    do_pop;

   assign full       = count_ff == CNT_WIDTH'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
      if (do_push) store_ff[wr_ptr_ff] <= push_data;
   end

`ifndef SYNTHESIS
   // no push into a full queue, no pop from an empty one
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("queue pop while empty");
   // fill count stays within the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(DEPTH))
      else $error("queue fill count beyond depth");
`endif

endmodule

### sv/crdm_back.sv
`timescale 1ns / 1ps
// back end: walks the sixteen rows of the queue head into the output register
// depends on crdm_pkg

module crdm_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 head_valid,
   input  crdm_pkg::digits_type                 head_data,
   output logic                                 pop,
   output logic                                 out_valid,
   input  logic                                 out_stall,
   output logic [crdm_pkg::ROW_WIDTH-1:0]       out_row_address,
   output logic [crdm_pkg::PIX_WIDTH-1:0]       out_row_bits,
   output logic                                 out_last_row
);

   logic                                 out_load;
   logic                                 emit;
   logic [crdm_pkg::ROW_WIDTH-1:0]       row_ff;
   logic [crdm_pkg::ROW_WIDTH-1:0]       row_in;
   logic                                 valid_ff;
   logic [crdm_pkg::ROW_WIDTH-1:0]       addr_ff;
   logic [crdm_pkg::PIX_WIDTH-1:0]       bits_ff;
   logic                                 last_ff;

   // a row leaves whenever the output register is free or being taken
   assign out_load = !valid_ff || !out_stall;
   assign emit     = head_valid && out_load;
   assign pop      = emit && (row_ff == crdm_pkg::ROW_LAST);
   assign row_in   = row_ff + 1'b1;

   assign out_valid       = valid_ff;
   assign out_row_address = addr_ff;
   assign out_row_bits    = bits_ff;
   assign out_last_row    = last_ff;

   // row counter and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (emit)     row_ff   <= row_in;
         if (out_load) valid_ff <= head_valid;
      end
      if (emit) begin
         addr_ff <= row_ff;
         bits_ff <= ~crdm_pkg::row_pixels(head_data, row_ff);
         last_ff <= row_ff == crdm_pkg::ROW_LAST;
      end
   end

`ifndef SYNTHESIS
   // the counter only sits mid-frame while an item is at the head
   assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> row_ff == '0)
      else $error("row counter mid-frame with empty queue");
   // last row flag only on the final row address
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && last_ff |-> addr_ff == crdm_pkg::ROW_LAST)
      else $error("last row flag on wrong row");
   // rows of a frame go out in order
   assert property (@(posedge clock) disable iff (reset)
      emit && row_ff != '0 |-> addr_ff == row_ff - 1'b1)
      else $error("row sequence broken");
`endif

endmodule

### sv/countdown_digit_matrix_renderer_core.sv
`timescale 1ns / 1ps
// Countdown matrix renderer: a signed seconds count in, sixteen rows of a
// 16x16 LED frame out (minutes, colon, tens, units; pixels inverted).
// Channels: req_ (req_valid, req_stall, req_seconds) carries one count per
// transaction; rsp_ (rsp_valid, rsp_stall, rsp_row_address, rsp_row_bits,
// rsp_last_row) carries one row per transaction, rows 0 to 15 in order,
// rsp_last_row marking row 15. A transaction moves at a clock edge with valid
// high and stall low.
// The first row of a count reaches rsp_ after the edge that accepts it, through
// the second front stage, the queue write and the output register.
// The back end row counter feeding the single output register sends one row
// per cycle while a count is at the queue head and rsp_stall is low.
// The front accepts new counts while the back end is still drawing, until
// the front stages and the queue are full; then req_stall rises.
// When rsp_stall is high the output register holds its row and the back end
// pauses; the queue and front stages fill and then stall the input.
// Reset (synchronous, active high) empties the pipeline and the queue and
// returns the row counter to row 0; no clearing pass is needed.
// depends on crdm_pkg, crdm_front, crdm_queue, crdm_back

module countdown_digit_matrix_renderer_core #(
   parameter int QUEUE_DEPTH = crdm_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [crdm_pkg::SECONDS_WIDTH-1:0]  req_seconds,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [crdm_pkg::ROW_WIDTH-1:0]      rsp_row_address,
   output logic [crdm_pkg::PIX_WIDTH-1:0]      rsp_row_bits,
   output logic                                rsp_last_row
);

   logic                  front_valid;
   logic                  queue_full;
   crdm_pkg::digits_type  front_data;
   logic                  queue_pop;
   logic                  head_valid;
   crdm_pkg::digits_type  head_data;

   // accept and decode
   crdm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_seconds (req_seconds),
      .out_valid  (front_valid),
      .out_ready  (!queue_full),
      .out_data   (front_data)
   );

   // decoupling queue
   crdm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid && !queue_full),
      .push_data  (front_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // row generation
   crdm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_data       (head_data),
      .pop             (queue_pop),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .out_row_address (rsp_row_address),
      .out_row_bits    (rsp_row_bits),
      .out_last_row    (rsp_last_row)
   );

endmodule

### verif/countdown_digit_matrix_renderer_core_tb.sv
`timescale 1ns / 1ps
// self-checking bench for countdown_digit_matrix_renderer_core: drives counts, predicts the
// sixteen rows of each frame and compares every row transaction in order
// depends on crdm_pkg and the renderer core rtl

module countdown_digit_matrix_renderer_core_tb;

   localparam int ROW_COUNT       = 16;
   localparam int RSP_LATENCY     = 4;
   localparam int STALL_LIMIT     = 5000;
   localparam int RANDOM_PER_PASS = 100;
   localparam int MAX_REPORTS     = 10;
   localparam logic [15:0] COLON_ROW_PIXELS = 16'h0140;

   // one row of the rendered frame
   typedef struct {
      logic [3:0]  addr;
      logic [15:0] bits;
      logic        last;
   } matrix_row_type;

   // expected rows of every accepted count, oldest first
   class frame_scoreboard;
      matrix_row_type rows_due[$];
      int             mismatches;

      function new();
         mismatches = 0;
      endfunction

      // column of a glyph, font packed as col0..col3 from the top byte down
      function logic [6:0] font_column(int glyph, int col);
         logic [31:0] cols;
         case (glyph)
            0:       cols = 32'h3E41413E;
            1:       cols = 32'h00427F40;
            2:       cols = 32'h66514946;
            3:       cols = 32'h22494936;
            4:       cols = 32'h1C127F10;
            5:       cols = 32'h27454539;
            6:       cols = 32'h3C4A4930;
            7:       cols = 32'h01710907;
            8:       cols = 32'h36494936;
            9:       cols = 32'h0649291E;
            default: cols = 32'h005F5F00;
         endcase
         return 7'(cols >> (8 * (3 - col)));
      endfunction

      // render the frame of one accepted count
      function void note_count(logic [15:0] seconds);
         int             count;
         int             mins;
         int             tens;
         int             units;
         int             row;
         logic [15:0]    pix;
         matrix_row_type r;
         count = seconds[15] ? 0 : int'(seconds);
         mins  = count / 60;
         if (mins > 10) mins = 10;
         tens  = (count % 60) / 10;
         units = count % 10;
         for (row = 0; row < ROW_COUNT; row++) begin
            if (row < 4)
               pix = 16'(font_column(mins, row)) << 4;
            else if (row == 5)
               pix = COLON_ROW_PIXELS;
            else if (row >= 7 && row <= 10)
               pix = 16'(font_column(tens, row - 7)) << 4;
            else if (row >= 12)
               pix = 16'(font_column(units, row - 12)) << 4;
            else
               pix = '0;
            r.addr = 4'(row);
            r.bits = ~pix;
            r.last = (row == ROW_COUNT - 1);
            rows_due.push_back(r);
         end
      endfunction

      // compare one row transaction with the oldest expected row
      function void check_row(logic [3:0] addr, logic [15:0] bits, logic last);
         matrix_row_type r;
         if (rows_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: row %0d bits %h last %b with no row expected",
                        $time, addr, bits, last);
            return;
         end
         r = rows_due.pop_front();
         if (addr !== r.addr || bits !== r.bits || last !== r.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display(
                  "%0t: exp addr %0d bits %h last %b, got addr %0d bits %h last %b",
                  $time, r.addr, r.bits, r.last, addr, bits, last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_seconds;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_row_address;
   logic [15:0] rsp_row_bits;
   logic        rsp_last_row;

   frame_scoreboard frames = new();
   int sender_idle_pct;
   int receiver_idle_pct;
   int quiet_cycles;

   countdown_digit_matrix_renderer_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_seconds     (req_seconds),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_row_address (rsp_row_address),
      .rsp_row_bits    (rsp_row_bits),
      .rsp_last_row    (rsp_last_row)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // monitor both channels and the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            frames.note_count(req_seconds);
         if (rsp_valid && !rsp_stall)
            frames.check_row(rsp_row_address, rsp_row_bits, rsp_last_row);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // offer one count, entered and left just after a falling edge
   task automatic send_count(input logic [15:0] seconds);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_seconds <= seconds;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // random count, weighted towards the ranges that change the glyphs
   function automatic logic [15:0] pick_seconds();
      case ($urandom_range(3))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(599));
         2:       return 16'($urandom_range(3000, 600));
         default: return 16'h8000 | 16'($urandom);
      endcase
   endfunction

   task automatic send_random(input int items, input int send_pct, input int recv_pct);
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      repeat (items) send_count(pick_seconds());
   endtask

   // every minute and unit glyph, all tens, clamping, negatives and bit extremes
   logic [15:0] directed_counts [21] = '{
      16'd0, 16'd71, 16'd142, 16'd213, 16'd284, 16'd355, 16'd366, 16'd437,
      16'd508, 16'd579, 16'd59, 16'd60, 16'd599, 16'd600, 16'd659, 16'd3599,
      16'h7FFF, 16'hFFFF, 16'h8000, 16'h5555, 16'h2AAA
   };

   // stimulus and end of run
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_seconds       = '0;
      rsp_stall         = 1'b0;
      sender_idle_pct   = 23;
      receiver_idle_pct = 81;
      quiet_cycles      = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_counts[i]) send_count(directed_counts[i]);
      send_random(RANDOM_PER_PASS, 23, 81);
      send_random(RANDOM_PER_PASS, 81, 23);
      send_random(RANDOM_PER_PASS, 0, 0);
      req_valid <= 1'b0;

      while (frames.rows_due.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 4) @(posedge clock);

      if (frames.mismatches == 0 && frames.rows_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### filelist.f
sv/crdm_pkg.sv
sv/crdm_front.sv
sv/crdm_queue.sv
sv/crdm_back.sv
sv/countdown_digit_matrix_renderer_core.sv
verif/countdown_digit_matrix_renderer_core_tb.sv
